// ----- sv/tlpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// types and constants shared by the page table manager
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam logic [1:0] REQ_MAP    = 2'd0;
	localparam logic [1:0] REQ_UNMAP  = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_MISALIGNED = 3'd1;
	localparam logic [2:0] ST_NO_TABLE   = 3'd2;
	localparam logic [2:0] ST_ALREADY    = 3'd3;
	localparam logic [2:0] ST_NOT_MAPPED = 3'd4;

	localparam int DIR_BITS  = 10;
	localparam int PTE_BITS  = 10;
	localparam int PE_WIDTH  = 23;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] virt_addr;
		logic [31:0] phys_addr;
		logic [2:0]  page_flags;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [31:0] mapped_addr;
	} rsp_t;

endpackage

// ----- sv/tlpt_dir.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_dir
// directory store: present bit, user bit and slot in one memory, cleared by
// a pass over all entries after reset
// ----------------------------------------------------------------------------
module tlpt_dir #(
	parameter int SLOT_W = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tlpt_pkg::DIR_BITS-1:0] rd_idx,
	output logic                         rd_present,
	output logic [SLOT_W-1:0]            rd_slot,
	input  logic                         wr_en,
	input  logic [tlpt_pkg::DIR_BITS-1:0] wr_idx,
	input  logic [SLOT_W-1:0]            wr_slot,
	input  logic                         wr_user,
	output logic                         busy
);
	import tlpt_pkg::*;

	localparam int DEPTH = 1 << DIR_BITS;

	logic [SLOT_W+1:0]   mem [DEPTH];
	logic [SLOT_W+1:0]   rd_q;
	logic [DIR_BITS-1:0] init_q;
	logic                busy_q;

	// clearing pass, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			init_q <= init_q + DIR_BITS'(1);
			if (init_q == '1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_idx];
		if (busy_q) mem[init_q] <= '0;
		else if (wr_en) mem[wr_idx] <= {1'b1, wr_user, wr_slot};
	end

	assign busy       = busy_q;
	assign rd_present = rd_q[SLOT_W+1];
	assign rd_slot    = rd_q[SLOT_W-1:0];
endmodule

// ----- sv/tlpt_pte.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pte
// page entry memory, one read and one write port, registered read
// ----------------------------------------------------------------------------
module tlpt_pte #(
	parameter int AW = 14
) (
	input  logic                          clk,
	input  logic [AW-1:0]                 rd_addr,
	output logic [tlpt_pkg::PE_WIDTH-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [tlpt_pkg::PE_WIDTH-1:0] wr_data
);
	import tlpt_pkg::*;

	logic [PE_WIDTH-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
	end
endmodule

// ----- sv/two_level_page_table_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// map, unmap and lookup on a two-level page table kept in memories
// ----------------------------------------------------------------------------
// requests arrive on req (req_valid/req_stall), one result per request
// leaves on rsp (rsp_valid/rsp_stall) through an output register.
// a request that reaches its entry goes accept, directory read, entry read,
// entry check and write, result, and the next request is taken in the cycle
// after the result transfers.
// a misaligned request, a full pool, an unknown code, or an unmap or lookup
// with no table ends after the directory read.
// a map that takes a fresh table first clears it, one entry a cycle, before
// the entry read.
// no request is taken while one is in flight or a result waits.
// reset clears the pool count and the result valid, then the directory is
// cleared one entry a cycle with requests stalled; entry memories need no
// clearing.
// a stalled result holds and blocks new requests until transferred.
// ----------------------------------------------------------------------------
module two_level_page_table_manager #(
	parameter int TABLE_POOL = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  tlpt_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output tlpt_pkg::rsp_t   rsp
);
	import tlpt_pkg::*;

	localparam int SLOT_W = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
	localparam int CNT_W  = $clog2(TABLE_POOL + 1);
	localparam int AW     = SLOT_W + PTE_BITS;

	typedef enum logic [2:0] {S_IDLE, S_DIR, S_CLEAR, S_RD, S_PTE, S_DONE} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [CNT_W-1:0]    used_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PTE_BITS-1:0] clr_q;

	logic                dir_present;
	logic [SLOT_W-1:0]   dir_slot;
	logic                dir_wr;
	logic                dir_busy;
	logic [PE_WIDTH-1:0] pte_rd;
	logic                pte_wr;
	logic [AW-1:0]       pte_waddr;
	logic [PE_WIDTH-1:0] pte_wdata;
	logic [AW-1:0]       pte_raddr;

	logic [DIR_BITS-1:0] dir_idx;
	logic [PTE_BITS-1:0] pte_idx;
	logic                va_mis, pa_mis;

	assign dir_idx = req_q.virt_addr[31:22];
	assign pte_idx = req_q.virt_addr[21:12];
	assign va_mis  = req_q.virt_addr[11:0] != 12'd0;
	assign pa_mis  = req_q.phys_addr[11:0] != 12'd0;

	assign req_stall = (state_q != S_IDLE) || rsp_valid || dir_busy;

	tlpt_dir #(.SLOT_W(SLOT_W)) u_dir (
		.clk(clk), .arst_n(arst_n),
		.rd_idx(req.virt_addr[31:22]),
		.rd_present(dir_present), .rd_slot(dir_slot),
		.wr_en(dir_wr), .wr_idx(dir_idx),
		.wr_slot(used_q[SLOT_W-1:0]), .wr_user(req_q.page_flags[2]),
		.busy(dir_busy)
	);

	assign pte_raddr = {slot_q, pte_idx};

	tlpt_pte #(.AW(AW)) u_pte (
		.clk(clk), .rd_addr(pte_raddr), .rd_data(pte_rd),
		.wr_en(pte_wr), .wr_addr(pte_waddr), .wr_data(pte_wdata)
	);

	logic need_table, pool_full;
	assign need_table = (req_q.req_type == REQ_MAP) && !va_mis && !pa_mis && !dir_present;
	assign pool_full  = used_q >= CNT_W'(TABLE_POOL);
	assign dir_wr     = (state_q == S_DIR) && need_table && !pool_full;

	always_comb begin
		pte_wr    = 1'b0;
		pte_waddr = pte_raddr;
		pte_wdata = '0;
		if (state_q == S_CLEAR) begin
			pte_wr    = 1'b1;
			pte_waddr = {slot_q, clr_q};
		end else if (state_q == S_PTE) begin
			if (req_q.req_type == REQ_MAP && !pte_rd[0]) begin
				pte_wr    = 1'b1;
				pte_wdata = {req_q.phys_addr[31:12], req_q.page_flags[2:1], 1'b1};
			end else if (req_q.req_type == REQ_UNMAP && pte_rd[0]) begin
				pte_wr = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			rsp_valid <= 1'b0;
			slot_q    <= '0;
			clr_q     <= '0;
		end else begin
			if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						req_q   <= req;
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					if (req_q.req_type == REQ_MAP) begin
						if (va_mis || pa_mis) begin
							rsp     <= '{status: ST_MISALIGNED, found: 1'b0, mapped_addr: 32'd0};
							state_q <= S_DONE;
						end else if (dir_present) begin
							rsp     <= '{status: ST_OK, found: 1'b0, mapped_addr: 32'd0};
							slot_q  <= dir_slot;
							state_q <= S_RD;
						end else if (pool_full) begin
							rsp     <= '{status: ST_NO_TABLE, found: 1'b0, mapped_addr: 32'd0};
							state_q <= S_DONE;
						end else begin
							rsp     <= '{status: ST_OK, found: 1'b0, mapped_addr: 32'd0};
							slot_q  <= used_q[SLOT_W-1:0];
							used_q  <= used_q + CNT_W'(1);
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end
					end else if (req_q.req_type == REQ_UNMAP
					             || req_q.req_type == REQ_LOOKUP) begin
						if (va_mis) begin
							rsp     <= '{status: ST_MISALIGNED, found: 1'b0, mapped_addr: 32'd0};
							state_q <= S_DONE;
						end else if (dir_present) begin
							rsp     <= '{status: ST_OK, found: 1'b0, mapped_addr: 32'd0};
							slot_q  <= dir_slot;
							state_q <= S_RD;
						end else begin
							rsp     <= '{status: ST_OK, found: 1'b0, mapped_addr: 32'd0};
							state_q <= S_DONE;
						end
					end else begin
						rsp     <= '{status: ST_OK, found: 1'b0, mapped_addr: 32'd0};
						state_q <= S_DONE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + PTE_BITS'(1);
					if (clr_q == '1) state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_PTE;
				end
				S_PTE: begin
					case (req_q.req_type)
						REQ_MAP:    if (pte_rd[0]) rsp.status <= ST_ALREADY;
						REQ_UNMAP:  if (!pte_rd[0]) rsp.status <= ST_NOT_MAPPED;
						REQ_LOOKUP: if (pte_rd[0]) begin
							rsp <= '{status: ST_OK, found: 1'b1,
								mapped_addr: {pte_rd[22:3], 12'd0}};
						end
						default: ;
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					rsp_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pool: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_POOL))
		else $error("pool count overflow");
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> state_q == S_IDLE || state_q == S_DIR)
		else $error("work started while result pending");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == ST_OK && rsp.mapped_addr[11:0] == 12'd0)
		else $error("bad found result");
	a_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		dir_wr |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("table taken without count");
`endif
endmodule

// ----- tb/tb_two_level_page_table_manager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_page_table_manager
// self-checking bench for the two-level page table manager: a directed table
// of requests, then random map/unmap/lookup traffic on a small set of pages,
// each result compared against a behavioral model of the tables
// ----------------------------------------------------------------------------
module tb_two_level_page_table_manager;
	import tlpt_pkg::*;

	localparam int POOL = 16;
	localparam int N_RANDOM = 2000;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	two_level_page_table_manager #(.TABLE_POOL(POOL)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// page table model
	bit dir_used [1024];
	int dir_slot [1024];
	logic [22:0] pte_mem [int];
	int pool_taken;
	rsp_t expected_rsp [$];
	int errors = 0;
	bit idle_on = 1'b1;
	bit hold_rsp = 1'b0;
	bit stim_done = 1'b0;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t x;
	} vec_t;

	function automatic rsp_t table_update(req_t r);
		rsp_t o;
		int d;
		int k;
		logic [22:0] e;
		o = '0;
		d = r.virt_addr[31:22];
		if (r.req_type == REQ_MAP) begin
			if (r.virt_addr[11:0] != 0 || r.phys_addr[11:0] != 0) begin
				o.status = ST_MISALIGNED;
			end else if (!dir_used[d] && pool_taken >= POOL) begin
				o.status = ST_NO_TABLE;
			end else begin
				if (!dir_used[d]) begin
					for (int i = 0; i < 1024; i++)
						pte_mem[pool_taken*1024 + i] = '0;
					dir_slot[d] = pool_taken;
					dir_used[d] = 1'b1;
					pool_taken++;
				end
				k = dir_slot[d]*1024 + r.virt_addr[21:12];
				if (pte_mem[k][0]) begin
					o.status = ST_ALREADY;
				end else begin
					pte_mem[k] = {r.phys_addr[31:12], r.page_flags[2:1], 1'b1};
				end
			end
		end else if (r.req_type == REQ_UNMAP || r.req_type == REQ_LOOKUP) begin
			if (r.virt_addr[11:0] != 0) begin
				o.status = ST_MISALIGNED;
			end else if (dir_used[d]) begin
				k = dir_slot[d]*1024 + r.virt_addr[21:12];
				e = pte_mem[k];
				if (r.req_type == REQ_UNMAP) begin
					if (!e[0]) o.status = ST_NOT_MAPPED;
					else pte_mem[k] = '0;
				end else if (e[0]) begin
					o.found = 1'b1;
					o.mapped_addr = {e[22:3], 12'h000};
				end
			end
		end
		return o;
	endfunction

	// random request on a narrow set of directories and pages
	function automatic req_t rand_req();
		req_t r;
		int p;
		p = $urandom_range(99);
		r.req_type = (p < 3) ? REQ_UNKNOWN : p < 45 ? REQ_MAP : p < 70 ? REQ_UNMAP : REQ_LOOKUP;
		r.virt_addr = {$urandom_range(1023) % 24 == 0 ? 10'($urandom) : 10'($urandom_range(19)),
			10'($urandom_range(7)) ^ ($urandom_range(9) == 0 ? 10'($urandom) : 10'd0), 12'h000};
		r.phys_addr = $urandom & 32'hFFFF_F000;
		if ($urandom_range(19) == 0) r.virt_addr[11:0] = 12'($urandom);
		if ($urandom_range(19) == 0) r.phys_addr[11:0] = 12'($urandom);
		r.page_flags = 3'($urandom);
		return r;
	endfunction

	task automatic send(req_t r);
		int gap;
		if (idle_on && $urandom_range(5) == 0) begin
			gap = $urandom_range(17, 1);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_rsp.push_back(table_update(r));
		@(negedge clk);
	endtask

	task automatic send_typed(vec_t v);
		rsp_t p;
		send(v.r);
		if (v.typed) begin
			p = expected_rsp[$];
			if (p !== v.x) begin
				$display("%0t table row expected %h model %h", $time, v.x, p);
				errors++;
			end
		end
	endtask

	function automatic vec_t row(logic [1:0] t, logic [31:0] va, logic [31:0] pa,
		logic [2:0] f, bit ty, logic [2:0] st, logic fd, logic [31:0] ma);
		vec_t v;
		v.r = '{t, va, pa, f};
		v.typed = ty;
		v.x = '{st, fd, ma};
		return v;
	endfunction

	initial begin
		vec_t dirv [$];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		dirv.push_back(row(REQ_LOOKUP, 32'h0, 32'h0, 3'd0, 1, ST_OK, 0, 0));
		dirv.push_back(row(REQ_UNMAP, 32'h0, 32'h0, 3'd0, 1, ST_OK, 0, 0));
		dirv.push_back(row(REQ_MAP, 32'h0000_0001, 32'h0, 3'd7, 1, ST_MISALIGNED, 0, 0));
		dirv.push_back(row(REQ_MAP, 32'h0, 32'h0000_0800, 3'd7, 1, ST_MISALIGNED, 0, 0));
		dirv.push_back(row(REQ_UNMAP, 32'hFFFF_FFFF, 32'h0, 3'd0, 1, ST_MISALIGNED, 0, 0));
		dirv.push_back(row(REQ_LOOKUP, 32'h0000_0FFF, 32'h0, 3'd0, 1, ST_MISALIGNED, 0, 0));
		dirv.push_back(row(REQ_MAP, 32'hFFFF_F000, 32'hFFFF_F000, 3'd7, 1, ST_OK, 0, 0));
		dirv.push_back(row(REQ_LOOKUP, 32'hFFFF_F000, 32'h0, 3'd0, 1, ST_OK, 1, 32'hFFFF_F000));
		dirv.push_back(row(REQ_MAP, 32'hFFFF_F000, 32'h1000, 3'd0, 1, ST_ALREADY, 0, 0));
		dirv.push_back(row(REQ_UNMAP, 32'hFFFF_E000, 32'h0, 3'd0, 1, ST_NOT_MAPPED, 0, 0));
		dirv.push_back(row(REQ_MAP, 32'h0, 32'h0, 3'd0, 0, 0, 0, 0));
		dirv.push_back(row(REQ_LOOKUP, 32'h0, 32'h0, 3'd0, 1, ST_OK, 1, 32'h0));
		dirv.push_back(row(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1, ST_OK, 0, 0));
		dirv.push_back(row(REQ_UNMAP, 32'hFFFF_F000, 32'h0, 3'd0, 1, ST_OK, 0, 0));
		dirv.push_back(row(REQ_LOOKUP, 32'hFFFF_F000, 32'h0, 3'd0, 1, ST_OK, 0, 0));
		// use up the pool with maps to new directories; the last one finds no table
		for (int i = 1; i < POOL + 2; i++)
			dirv.push_back(row(REQ_MAP, (i << 22), (i << 12), 3'($urandom), 0, 0, 0, 0));
		dirv[$].typed = 1'b1;
		dirv[$].x = '{ST_NO_TABLE, 1'b0, 32'h0};
		foreach (dirv[i]) send_typed(dirv[i]);
		// receiver holds off while the sender keeps offering
		hold_rsp = 1'b1;
		for (int i = 0; i < 8; i++) send(rand_req());
		req_valid <= 1'b0;
		wait (expected_rsp.size() == 0);
		@(negedge clk);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				req_valid <= 1'b0;
				wait (expected_rsp.size() == 0);
				@(negedge clk);
			end
			if (i == N_RANDOM - 200) idle_on = 1'b0;
			send(rand_req());
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// response side stall
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (60) @(negedge clk);
				rsp_stall <= 1'b0;
				hold_rsp = 1'b0;
			end else if (idle_on && $urandom_range(7) == 0) begin
				n = $urandom_range(17, 1);
				rsp_stall <= 1'b1;
				repeat (n) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected transfer, actual %h", $time, rsp);
				errors++;
			end else begin
				rsp_t x;
				x = expected_rsp.pop_front();
				if (rsp.status !== x.status || rsp.found !== x.found ||
					rsp.mapped_addr !== x.mapped_addr) begin
					$display("%0t expected %h actual %h", $time, x, rsp);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done && expected_rsp.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("two_level_page_table_manager: match");
		end else begin
			$display("two_level_page_table_manager: mismatch");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("two_level_page_table_manager: mismatch");
		$finish;
	end

endmodule
